// ===== rtl/lbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared types and constants for the bounded random number server.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

	// generator constants
	localparam int unsigned LCG_W      = 31;
	localparam logic [LCG_W-1:0] LCG_MUL   = 31'(32'd1103515245);
	localparam logic [LCG_W-1:0] LCG_INC   = 31'd12345;
	localparam logic [LCG_W-1:0] SEED_RST  = 31'd1;

	// draw and item widths
	localparam int unsigned FRAC_W     = 24;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 56;
	localparam int unsigned CNT_W      = 5;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_W - 1);

	// request kinds, the unused code is served as a fraction draw
	typedef enum logic [OP_W-1:0] {
		OP_FRAC     = 2'd0,
		OP_UNSIGNED = 2'd1,
		OP_SIGNED   = 2'd2
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

endpackage : lbr_pkg

`default_nettype wire

// ===== rtl/lbr_lcg.sv =====
// ----------------------------------------------------------------------------
// lbr_lcg
// 31-bit linear congruential generator state with seed load and advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_lcg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [lbr_pkg::LCG_W-1:0] seed,
	input  wire logic                   advance,
	output logic [lbr_pkg::LCG_W-1:0]   state
);

	logic [lbr_pkg::LCG_W-1:0] state_q;
	logic [lbr_pkg::LCG_W-1:0] next_state;

	// x' = a*x + c, only the low 31 bits are kept
	assign next_state = lbr_pkg::LCG_W'(state_q * lbr_pkg::LCG_MUL + lbr_pkg::LCG_INC);

	// state register, a seed write wins over an advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbr_pkg::SEED_RST;
		end else if (load) begin
			state_q <= seed;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	assign state = state_q;

endmodule : lbr_lcg

`default_nettype wire

// ===== rtl/lcg_bounded_random.sv =====
// ----------------------------------------------------------------------------
// lcg_bounded_random
// Random number server: fraction draws and bounded integer draws.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on s_tvalid/s_tready/s_tdata and carries op, range_start
//   and range_end. One result item leaves on m_tvalid/m_tready/m_tdata with
//   the drawn value and the 24-bit draw. One item is in work at a time;
//   s_tready is high only while the sequencer is idle.
//   Fraction draws and empty ranges go from setup straight to the done
//   state. Range draws run 24 steps of one shared 33-bit add/subtract unit
//   (restoring remainder for ranges below 2^24, shift-add multiply for wider
//   ranges) before the done state; a new item is taken only once the
//   sequencer is back in idle.
//   The result sits in an output register; a stalled receiver holds it and
//   a finished item waits in the sequencer until that register is free.
//   cfg_valid/cfg_ready/cfg_data writes the seed and reloads the generator;
//   cfg_ready is high while idle. Reset loads the generator with seed 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_bounded_random (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// op [1:0], range_start [33:2], range_end [65:34], zero fill above
	input  wire logic [lbr_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// value [31:0], fraction [55:32]
	output logic [lbr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [lbr_pkg::LCG_W-1:0]     cfg_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready
);

	lbr_pkg::state_t state_q, state_d;

	logic [lbr_pkg::OP_W-1:0]   op_q;
	logic [lbr_pkg::DATA_W-1:0] start_q;
	logic [lbr_pkg::DATA_W-1:0] end_q;
	logic [lbr_pkg::DATA_W-1:0] range_q;
	logic [lbr_pkg::FRAC_W-1:0] r_q;
	logic [lbr_pkg::FRAC_W-1:0] frac_q;
	logic [lbr_pkg::DATA_W:0]   acc_q;
	logic [lbr_pkg::CNT_W-1:0]  cnt_q;
	logic                       add_start_q;

	logic [lbr_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                            m_tvalid_q;

	logic [lbr_pkg::LCG_W-1:0]  lcg_state;
	logic [lbr_pkg::FRAC_W-1:0] draw;
	logic                       advance;
	logic                       is_range;
	logic                       empty;
	logic [lbr_pkg::DATA_W-1:0] range_d;
	logic                       out_free;
	logic                       last_step;
	logic [lbr_pkg::DATA_W-1:0] value_out;

	// shared add/subtract unit
	logic [lbr_pkg::DATA_W:0]   alu_a;
	logic [lbr_pkg::DATA_W:0]   alu_b;
	logic                       alu_cin;
	logic [lbr_pkg::DATA_W+1:0] alu_sum;
	logic [lbr_pkg::FRAC_W:0]   div_shift;

	assign s_tready  = (state_q == lbr_pkg::ST_IDLE);
	assign cfg_ready = (state_q == lbr_pkg::ST_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_step = (cnt_q == lbr_pkg::LAST_STEP);

	// generator
	assign draw = lcg_state[29:6];

	lbr_lcg u_lcg (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (cfg_valid && cfg_ready),
		.seed    (cfg_data),
		.advance (advance),
		.state   (lcg_state)
	);

	// request decode for the setup step
	always_comb begin
		is_range = 1'b0;
		empty    = 1'b0;
		case (lbr_pkg::op_t'(op_q))
			lbr_pkg::OP_UNSIGNED: begin
				is_range = 1'b1;
				empty    = (end_q <= start_q);
			end
			lbr_pkg::OP_SIGNED: begin
				is_range = 1'b1;
				empty    = ($signed(end_q) <= $signed(start_q));
			end
			default: begin
				is_range = 1'b0;
				empty    = 1'b0;
			end
		endcase
	end

	assign range_d = end_q - start_q;
	assign advance = (state_q == lbr_pkg::ST_SETUP) && !(is_range && empty);

	// operand select: remainder trial subtract or multiply accumulate
	assign div_shift = {acc_q[lbr_pkg::FRAC_W-1:0], r_q[lbr_pkg::FRAC_W-1]};

	always_comb begin
		if (state_q == lbr_pkg::ST_DIV) begin
			alu_a   = (lbr_pkg::DATA_W+1)'(div_shift);
			alu_b   = ~{1'b0, range_q};
			alu_cin = 1'b1;
		end else begin
			alu_a   = acc_q;
			alu_b   = r_q[0] ? {1'b0, range_q} : '0;
			alu_cin = 1'b0;
		end
	end

	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (lbr_pkg::DATA_W+2)'(alu_cin);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lbr_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = lbr_pkg::ST_SETUP;
			end
			lbr_pkg::ST_SETUP: begin
				if (!is_range || empty) begin
					state_d = lbr_pkg::ST_DONE;
				end else if (range_d[lbr_pkg::DATA_W-1:lbr_pkg::FRAC_W] != '0) begin
					state_d = lbr_pkg::ST_MUL;
				end else begin
					state_d = lbr_pkg::ST_DIV;
				end
			end
			lbr_pkg::ST_DIV,
			lbr_pkg::ST_MUL: begin
				if (last_step) state_d = lbr_pkg::ST_DONE;
			end
			lbr_pkg::ST_DONE: begin
				if (out_free) state_d = lbr_pkg::ST_IDLE;
			end
			default: state_d = lbr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			lbr_pkg::ST_IDLE: begin
				op_q    <= s_tdata[1:0];
				start_q <= s_tdata[33:2];
				end_q   <= s_tdata[65:34];
			end
			lbr_pkg::ST_SETUP: begin
				cnt_q   <= '0;
				range_q <= range_d;
				r_q     <= draw;
				if (is_range && empty) begin
					acc_q       <= {1'b0, start_q};
					frac_q      <= '0;
					add_start_q <= 1'b0;
				end else if (is_range) begin
					acc_q       <= '0;
					frac_q      <= draw;
					add_start_q <= 1'b1;
				end else begin
					acc_q       <= (lbr_pkg::DATA_W+1)'(draw);
					frac_q      <= draw;
					add_start_q <= 1'b0;
				end
			end
			lbr_pkg::ST_DIV: begin
				// restoring remainder step, keep the difference when no borrow
				cnt_q <= cnt_q + 1'b1;
				r_q   <= r_q << 1;
				if (alu_sum[lbr_pkg::DATA_W+1]) begin
					acc_q <= alu_sum[lbr_pkg::DATA_W:0];
				end else begin
					acc_q <= (lbr_pkg::DATA_W+1)'(div_shift);
				end
			end
			lbr_pkg::ST_MUL: begin
				// shift-add step, only the high product half is kept
				cnt_q <= cnt_q + 1'b1;
				r_q   <= r_q >> 1;
				acc_q <= {1'b0, alu_sum[lbr_pkg::DATA_W:1]};
			end
			default: begin
			end
		endcase
	end

	// result value, offset by start for range draws
	assign value_out = add_start_q ? (start_q + acc_q[lbr_pkg::DATA_W-1:0])
	                               : acc_q[lbr_pkg::DATA_W-1:0];

	// output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == lbr_pkg::ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbr_pkg::ST_DONE && out_free) begin
			m_tdata_q <= {frac_q, value_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule : lcg_bounded_random

`default_nettype wire

// ===== tb/sv/lcg_bounded_random_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_bounded_random_tb
// Self-checking bench for the bounded random number server. A clocked driver
// feeds request items from a queue, a clocked sink takes result items with
// random stalls, and an in-bench generator model predicts every draw. The run
// walks through several seeds, directed corner requests and random bounds.
// ----------------------------------------------------------------------------

module lcg_bounded_random_tb;

	import lbr_pkg::*;

	// spare request code, served like a fraction draw
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [DATA_W-1:0] FRAC_ONE = DATA_W'(1) << FRAC_W;
	localparam int unsigned GAP_MAX        = 11;
	localparam int unsigned BACKLOG_CYCLES = 200;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned IDLE_LIMIT     = 3000;
	localparam int unsigned PHASE_ITEMS    = 222;
	localparam int unsigned PRINT_MAX      = 40;

	// request item, op in the lowest bits
	typedef struct packed {
		logic [DATA_W-1:0] range_end;
		logic [DATA_W-1:0] range_start;
		logic [OP_W-1:0]   op;
	} req_t;

	// result item, value in the lowest bits
	typedef struct packed {
		logic [FRAC_W-1:0] fraction;
		logic [DATA_W-1:0] value;
	} draw_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	// op [1:0], range_start [33:2], range_end [65:34], zero fill above
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// value [31:0], fraction [55:32]
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [LCG_W-1:0]       cfg_data = '0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;

	// registered handshakes, seen by the falling-edge processes
	logic s_fire = 1'b0;
	logic m_fire = 1'b0;
	logic cfg_fire = 1'b0;

	req_t        pending_reqs[$];
	draw_t       expected_draws[$];
	logic [LCG_W-1:0] gen_state = SEED_RST;
	int unsigned src_hold = 0;
	int unsigned sink_hold = 0;
	int unsigned src_gap_max = GAP_MAX;
	int unsigned sink_gap_max = GAP_MAX;
	int unsigned backlog_req = 0;
	int unsigned backlog_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned error_count = 0;

	lcg_bounded_random dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_data  (cfg_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (error_count < PRINT_MAX)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// generator model: expected result of one request, advances the state
	function automatic draw_t predict_draw(input req_t q);
		draw_t             d;
		logic [FRAC_W-1:0] r;
		logic [DATA_W-1:0] span;
		logic [55:0]       prod;
		logic [62:0]       nxt;
		logic              empty;
		empty = 1'b0;
		if (q.op == OP_UNSIGNED)
			empty = q.range_end <= q.range_start;
		else if (q.op == OP_SIGNED)
			empty = $signed(q.range_end) <= $signed(q.range_start);
		if (empty) begin
			d.value = q.range_start;
			d.fraction = '0;
			return d;
		end
		r = gen_state[29:6];
		nxt = 63'(gen_state) * 63'(LCG_MUL) + 63'(LCG_INC);
		gen_state = nxt[LCG_W-1:0];
		d.fraction = r;
		if (q.op == OP_UNSIGNED || q.op == OP_SIGNED) begin
			span = q.range_end - q.range_start;
			// wide ranges scale the draw, narrow ones take a remainder
			if (span >= FRAC_ONE) begin
				prod = 56'(r) * 56'(span);
				d.value = q.range_start + prod[55:24];
			end else begin
				d.value = q.range_start + DATA_W'(r) % span;
			end
		end else begin
			d.value = DATA_W'(r);
		end
		return d;
	endfunction

	function automatic req_t make_req(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
		req_t q;
		q.op = op;
		q.range_start = lo;
		q.range_end = hi;
		return q;
	endfunction

	// random request, mostly well-formed ranges of assorted widths
	function automatic req_t random_req();
		req_t              q;
		int unsigned       pick;
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] base;
		pick = $urandom_range(99);
		if (pick < 8)
			q.op = OP_FRAC;
		else if (pick < 12)
			q.op = OP_SPARE;
		else if (pick < 56)
			q.op = OP_UNSIGNED;
		else
			q.op = OP_SIGNED;
		q.range_start = $urandom;
		q.range_end = $urandom;
		pick = $urandom_range(9);
		if (pick < 8) begin
			case (pick)
				0, 1: span = $urandom_range(16, 1);
				2, 3: span = $urandom_range(FRAC_ONE - 1, 17);
				4: span = FRAC_ONE + $urandom_range(FRAC_ONE - 1, 0);
				5, 6: span = $urandom;
				default: span = '0;
			endcase
			// offset-binary base keeps the range inside the signed order too
			base = $urandom_range(32'hffff_ffff - span, 0);
			q.range_start = (q.op == OP_SIGNED) ? (base ^ 32'h8000_0000) : base;
			q.range_end = q.range_start + span;
		end
		return q;
	endfunction

	// request driver
	always @(negedge clk) begin : src_drive
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (src_hold > 0) begin
				s_tvalid <= 1'b0;
				src_hold <= src_hold - 1;
			end else if (pending_reqs.size() > 0) begin
				s_tdata <= IN_TDATA_W'(pending_reqs.pop_front());
				s_tvalid <= 1'b1;
				src_hold <= $urandom_range(src_gap_max);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink with per-item stalls and an occasional long hold-off
	always @(negedge clk) begin : sink_drive
		int unsigned g;
		if (backlog_seen != backlog_req) begin
			backlog_seen <= backlog_req;
			sink_hold <= BACKLOG_CYCLES;
			m_tready <= 1'b0;
		end else begin
			g = m_fire ? $urandom_range(sink_gap_max) : sink_hold;
			if (g > 0) begin
				m_tready <= 1'b0;
				sink_hold <= g - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: predict on request, check on result, track idle cycles
	always @(posedge clk) begin : monitor
		draw_t got;
		draw_t want;
		s_fire <= s_tvalid && s_tready;
		m_fire <= m_tvalid && m_tready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				gen_state = cfg_data;
			if (s_tvalid && s_tready)
				expected_draws.push_back(predict_draw(req_t'(s_tdata[$bits(req_t)-1:0])));
			if (m_tvalid && m_tready) begin
				got = draw_t'(m_tdata);
				if (expected_draws.size() == 0) begin
					report_error($sformatf("result %h with no draw pending", m_tdata));
				end else begin
					want = expected_draws.pop_front();
					if (got.value !== want.value)
						report_error($sformatf("value %h, want %h", got.value, want.value));
					if (got.fraction !== want.fraction)
						report_error($sformatf("fraction %h, want %h",
							got.fraction, want.fraction));
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// watchdog
	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	task automatic write_seed(input logic [LCG_W-1:0] seed);
		@(negedge clk);
		cfg_data <= seed;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_draws.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// stimulus sequence
	initial begin : stimulus
		logic [LCG_W-1:0] seed;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner requests on the reset seed
		pending_reqs.push_back(make_req(OP_FRAC, 32'h0, 32'h0));
		pending_reqs.push_back(make_req(OP_SPARE, 32'hffff_ffff, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h0, 32'h0));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h5, 32'h5));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'hffff_ffff, 32'h0));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h0, 32'h1));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h0, FRAC_ONE - 1));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'h0, FRAC_ONE));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'd10, 32'd20));
		pending_reqs.push_back(make_req(OP_UNSIGNED, 32'hffff_fffe, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'h0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'h8000_0000, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'h7fff_ffff, 32'h8000_0000));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'hffff_fff6, 32'd10));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'hffff_fff0, 32'hffff_ffff));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'h8000_0000, 32'h8000_0001));
		pending_reqs.push_back(make_req(OP_SIGNED, 32'hff00_0000, 32'h0));
		pending_reqs.push_back(make_req(OP_FRAC, 32'h1234_5678, 32'h9abc_def0));
		wait_drain();

		// random phases, each on its own seed
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: seed = '0;
				1: seed = '1;
				3: seed = SEED_RST;
				default: seed = LCG_W'($urandom);
			endcase
			write_seed(seed);
			// one phase runs with no idling on either side
			src_gap_max = (ph == 2) ? 0 : GAP_MAX;
			sink_gap_max = (ph == 2) ? 0 : GAP_MAX;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pending_reqs.push_back(random_req());
				// sender pause until all results are back
				if (ph == 4 && n == PHASE_ITEMS / 2)
					wait_drain();
			end
			// long receiver hold-off while the sender keeps offering
			if (ph == 3)
				backlog_req++;
			wait_drain();
		end

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
